@@ rtl/vdfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdfe_pkg
// Shared codes, widths and constants of the voxel distance-field engine.
// ----------------------------------------------------------------------------
package vdfe_pkg;

	// Request codes carried on s_tuser
	localparam logic [2:0] REQ_MARK    = 3'd0;
	localparam logic [2:0] REQ_CLEAR   = 3'd1;
	localparam logic [2:0] REQ_COMPUTE = 3'd2;
	localparam logic [2:0] REQ_QUERY   = 3'd3;
	localparam logic [2:0] REQ_FREE    = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_SIZE_X  = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y  = 2'd1;
	localparam logic [1:0] CFG_SIZE_Z  = 2'd2;
	localparam logic [1:0] CFG_UNKNOWN = 2'd3;

	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 40;

	// Signed coordinate width wide enough for an index plus any offset
	localparam int COORD_W = 9;
	localparam int RAD_W   = 4;

	localparam logic [15:0] DIST_INF = 16'hFFFF;
	localparam logic [15:0] DIST_MAX = 16'hFFFE;

	// sqrt(2) and sqrt(3) with 16 fraction bits
	localparam longint SQRT2_Q16 = 92682;
	localparam longint SQRT3_Q16 = 113512;

endpackage
`default_nettype wire

@@ rtl/voxel_distance_field_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_distance_field_engine_core
// Occupancy grid with a 26-connected distance transform, queries and
// spherical clearance checks.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result per
// request. After reset it runs a clearing pass over the whole memory before
// it takes its first request. A mark reads the occupancy bit and writes it
// when the voxel is inside and not yet set; a clear rewrites both memories in
// full; a free check scans the cube of side 2r+1 around the point, where r is
// the saturated radius. A field computation seeds the whole distance memory,
// then runs alternating forward and backward sweeps over the configured
// extent, each voxel taking 27 reads through the single distance read port
// (the voxel and its 26 neighbors), one drain and one write-back, repeated
// until a pair of sweeps changes nothing. The occupancy and distance memories
// each have one read and one write port.
module voxel_distance_field_engine_core #(
	parameter int MAX_DIM    = 32,
	parameter int MAX_RADIUS = 7,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [5:0]                    cfg_data,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// vox_x[6:0], vox_y[13:7], vox_z[20:14], clear_radius[23:21]
	input  wire logic [vdfe_pkg::S_DATA_W-1:0] s_tdata,
	// req_type[2:0]
	input  wire logic [vdfe_pkg::S_USER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// dist_value[15:0], is_occupied[16], is_free[17], in_map[18],
	// field_valid[19], occ_total[35:20], zero[39:36]
	output logic [vdfe_pkg::M_DATA_W-1:0]      m_tdata
);
	import vdfe_pkg::*;

	localparam int DW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int ESW   = $clog2(MAX_DIM + 1);
	localparam logic [DW-1:0] DIM_LAST = DW'(MAX_DIM - 1);

	localparam longint C2L = ((SQRT2_Q16 << FRAC_BITS) + 32768) >> 16;
	localparam longint C3L = ((SQRT3_Q16 << FRAC_BITS) + 32768) >> 16;
	localparam logic [15:0] COST1 = 16'(1 << FRAC_BITS);
	localparam logic [15:0] COST2 = 16'(C2L);
	localparam logic [15:0] COST3 = 16'(C3L);

	localparam logic [3:0] ST_INIT    = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_CLEAR   = 4'd2;
	localparam logic [3:0] ST_MARK_RD = 4'd3;
	localparam logic [3:0] ST_MARK_WR = 4'd4;
	localparam logic [3:0] ST_FI      = 4'd5;
	localparam logic [3:0] ST_FI_END  = 4'd6;
	localparam logic [3:0] ST_RX_RD   = 4'd7;
	localparam logic [3:0] ST_RX_WAIT = 4'd8;
	localparam logic [3:0] ST_RX_WB   = 4'd9;
	localparam logic [3:0] ST_FREE    = 4'd10;
	localparam logic [3:0] ST_FREE_END = 4'd11;
	localparam logic [3:0] ST_RES_RD  = 4'd12;
	localparam logic [3:0] ST_RES     = 4'd13;

	function automatic logic [ESW-1:0] eff_size(input logic [5:0] v);
		if (v == 6'd0) return ESW'(1);
		if (int'(v) > MAX_DIM) return ESW'(MAX_DIM);
		return ESW'(v);
	endfunction

	function automatic logic in_ext(input logic signed [COORD_W-1:0] c,
			input logic [ESW-1:0] es);
		return (c >= 0) && (c < $signed({{(COORD_W - ESW){1'b0}}, es}));
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [DW-1:0] x,
			input logic [DW-1:0] y, input logic [DW-1:0] z);
		return AW'((int'(x) * MAX_DIM + int'(y)) * MAX_DIM + int'(z));
	endfunction

	// Configuration
	logic [5:0] sx_q, sy_q, sz_q;
	logic       ub_q;
	logic [ESW-1:0] esx, esy, esz;

	// Request
	logic [3:0]              state_q;
	logic [2:0]              req_q;
	logic signed [6:0]       px_q, py_q, pz_q;
	logic [RAD_W-1:0]        rad_q;
	logic                    inside_q;
	logic signed [COORD_W-1:0] pxe, pye, pze, ixe, iye, ize;
	logic                    in_inside;
	logic [RAD_W-1:0]        in_rad;
	logic [AW-1:0]           req_addr;

	// Full-memory sweep
	logic [DW-1:0] cx_q, cy_q, cz_q;
	logic [AW-1:0] sweep_addr;
	logic          sweep_last;
	logic          fi_v_s1, fi_in_s1;
	logic [AW-1:0] fi_addr_s1;

	// Relaxation
	logic [DW-1:0] vx_q, vy_q, vz_q;
	logic          dir_q, changed_q;
	logic [1:0]    ni_q, nj_q, nk_q;
	logic [15:0]   best_q, center_q, best_nxt, cost_sel, cand;
	logic [16:0]   sum17;
	logic          rx_v_s1, rx_use_s1, take;
	logic [1:0]    rx_cls_s1, cls;
	logic signed [COORD_W-1:0] nx, ny, nz;
	logic          n_in, wr_now;
	logic [AW-1:0] n_addr, v_addr;

	// Free check
	logic signed [4:0] ox_q, oy_q, oz_q, rs, in_rneg;
	logic signed [COORD_W-1:0] fx, fy, fz;
	logic [9:0]    sqs, rr;
	logic          in_sph, f_in, fr_v_s1, free_ok_q, off_last;
	logic [AW-1:0] f_addr;

	// Status and output
	logic [15:0] occ_cnt_q;
	logic        ready_q;
	logic        m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [15:0] dv;
	logic        occ_v, accept;

	// Memories
	logic          occ_mem [DEPTH];
	logic [15:0]   dist_mem [DEPTH];
	logic          occ_rd_q;
	logic [15:0]   dist_rd_q;
	logic          occ_we, occ_wdata, dist_we;
	logic [AW-1:0] occ_raddr, occ_waddr, dist_raddr, dist_waddr;
	logic [15:0]   dist_wdata;

	assign esx = eff_size(sx_q);
	assign esy = eff_size(sy_q);
	assign esz = eff_size(sz_q);

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign ixe = $signed({{(COORD_W - 7){s_tdata[6]}}, s_tdata[6:0]});
	assign iye = $signed({{(COORD_W - 7){s_tdata[13]}}, s_tdata[13:7]});
	assign ize = $signed({{(COORD_W - 7){s_tdata[20]}}, s_tdata[20:14]});
	assign in_inside = in_ext(ixe, esx) && in_ext(iye, esy) && in_ext(ize, esz);
	assign in_rad = (int'(s_tdata[23:21]) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
		: RAD_W'(s_tdata[23:21]);
	assign in_rneg = 5'sd0 - $signed({1'b0, in_rad});

	assign pxe = $signed({{(COORD_W - 7){px_q[6]}}, px_q});
	assign pye = $signed({{(COORD_W - 7){py_q[6]}}, py_q});
	assign pze = $signed({{(COORD_W - 7){pz_q[6]}}, pz_q});
	assign req_addr = addr_of(px_q[DW-1:0], py_q[DW-1:0], pz_q[DW-1:0]);

	assign sweep_addr = addr_of(cx_q, cy_q, cz_q);
	assign sweep_last = (cx_q == DIM_LAST) && (cy_q == DIM_LAST) && (cz_q == DIM_LAST);

	// Neighbor of the voxel being relaxed; offsets are digit minus one
	assign nx = COORD_W'(vx_q) + COORD_W'(ni_q) - COORD_W'(1);
	assign ny = COORD_W'(vy_q) + COORD_W'(nj_q) - COORD_W'(1);
	assign nz = COORD_W'(vz_q) + COORD_W'(nk_q) - COORD_W'(1);
	assign n_in = in_ext(nx, esx) && in_ext(ny, esy) && in_ext(nz, esz);
	assign n_addr = addr_of(nx[DW-1:0], ny[DW-1:0], nz[DW-1:0]);
	assign v_addr = addr_of(vx_q, vy_q, vz_q);
	assign cls = 2'(ni_q != 2'd1) + 2'(nj_q != 2'd1) + 2'(nk_q != 2'd1);

	always_comb begin
		case (rx_cls_s1)
			2'd1:    cost_sel = COST1;
			2'd2:    cost_sel = COST2;
			default: cost_sel = COST3;
		endcase
		sum17 = {1'b0, dist_rd_q} + {1'b0, cost_sel};
		cand  = (sum17 > {1'b0, DIST_MAX}) ? DIST_MAX : sum17[15:0];
		take  = 1'b0;
		if (rx_v_s1) begin
			if (rx_cls_s1 == 2'd0) begin
				cand = dist_rd_q;
				take = 1'b1;
			end else begin
				take = rx_use_s1 && (dist_rd_q != DIST_INF);
			end
		end
		best_nxt = (take && (cand < best_q)) ? cand : best_q;
	end

	assign wr_now = best_q < center_q;

	// Free-check offset
	assign rs = $signed({1'b0, rad_q});
	assign fx = pxe + $signed({{(COORD_W - 5){ox_q[4]}}, ox_q});
	assign fy = pye + $signed({{(COORD_W - 5){oy_q[4]}}, oy_q});
	assign fz = pze + $signed({{(COORD_W - 5){oz_q[4]}}, oz_q});
	assign sqs = 10'(int'(ox_q) * int'(ox_q) + int'(oy_q) * int'(oy_q)
		+ int'(oz_q) * int'(oz_q));
	assign rr = 10'(int'(rad_q) * int'(rad_q));
	assign in_sph = sqs <= rr;
	assign f_in = in_ext(fx, esx) && in_ext(fy, esy) && in_ext(fz, esz);
	assign f_addr = addr_of(fx[DW-1:0], fy[DW-1:0], fz[DW-1:0]);
	assign off_last = (ox_q == rs) && (oy_q == rs) && (oz_q == rs);

	assign dv = inside_q ? dist_rd_q : (ub_q ? 16'd0 : DIST_INF);
	assign occ_v = inside_q ? occ_rd_q : ub_q;

	// Memory port control
	always_comb begin
		occ_raddr  = req_addr;
		dist_raddr = req_addr;
		occ_we     = 1'b0;
		occ_waddr  = sweep_addr;
		occ_wdata  = 1'b0;
		dist_we    = 1'b0;
		dist_waddr = sweep_addr;
		dist_wdata = DIST_INF;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				occ_we  = 1'b1;
				dist_we = 1'b1;
			end
			ST_MARK_WR: begin
				occ_we    = inside_q && !occ_rd_q;
				occ_waddr = req_addr;
				occ_wdata = 1'b1;
			end
			ST_FI:    occ_raddr = sweep_addr;
			ST_RX_RD: dist_raddr = n_addr;
			ST_RX_WB: begin
				dist_we    = wr_now;
				dist_waddr = v_addr;
				dist_wdata = best_q;
			end
			ST_FREE:  occ_raddr = f_addr;
			default: ;
		endcase
		// Seeding write follows the occupancy read in the next cycle
		if (fi_v_s1) begin
			dist_we    = 1'b1;
			dist_waddr = fi_addr_s1;
			dist_wdata = (fi_in_s1 && occ_rd_q) ? 16'd0 : DIST_INF;
		end
	end

	always_ff @(posedge clk) begin
		if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
		occ_rd_q <= occ_mem[occ_raddr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
		dist_rd_q <= dist_mem[dist_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= 6'd32;
			sy_q <= 6'd32;
			sz_q <= 6'd32;
			ub_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE_X:  sx_q <= cfg_data;
				CFG_SIZE_Y:  sy_q <= cfg_data;
				CFG_SIZE_Z:  sz_q <= cfg_data;
				CFG_UNKNOWN: ub_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			req_q      <= REQ_QUERY;
			px_q       <= '0;
			py_q       <= '0;
			pz_q       <= '0;
			rad_q      <= '0;
			inside_q   <= 1'b0;
			cx_q       <= '0;
			cy_q       <= '0;
			cz_q       <= '0;
			fi_v_s1    <= 1'b0;
			fi_in_s1   <= 1'b0;
			fi_addr_s1 <= '0;
			vx_q       <= '0;
			vy_q       <= '0;
			vz_q       <= '0;
			dir_q      <= 1'b0;
			changed_q  <= 1'b0;
			ni_q       <= '0;
			nj_q       <= '0;
			nk_q       <= '0;
			best_q     <= DIST_INF;
			center_q   <= DIST_INF;
			rx_v_s1    <= 1'b0;
			rx_use_s1  <= 1'b0;
			rx_cls_s1  <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
			oz_q       <= '0;
			fr_v_s1    <= 1'b0;
			free_ok_q  <= 1'b0;
			occ_cnt_q  <= '0;
			ready_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			fi_v_s1    <= (state_q == ST_FI);
			fi_in_s1   <= (ESW'(cx_q) < esx) && (ESW'(cy_q) < esy) && (ESW'(cz_q) < esz);
			fi_addr_s1 <= sweep_addr;
			rx_v_s1    <= (state_q == ST_RX_RD);
			rx_use_s1  <= n_in;
			rx_cls_s1  <= cls;
			fr_v_s1    <= (state_q == ST_FREE) && in_sph && f_in;
			best_q     <= best_nxt;
			if (rx_v_s1 && (rx_cls_s1 == 2'd0)) center_q <= dist_rd_q;
			if (fr_v_s1 && occ_rd_q) free_ok_q <= 1'b0;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;

			case (state_q)
				ST_INIT, ST_CLEAR, ST_FI: begin
					if (cz_q != DIM_LAST) begin
						cz_q <= cz_q + 1'b1;
					end else begin
						cz_q <= '0;
						if (cy_q != DIM_LAST) begin
							cy_q <= cy_q + 1'b1;
						end else begin
							cy_q <= '0;
							cx_q <= cx_q + 1'b1;
						end
					end
					if (sweep_last) begin
						case (state_q)
							ST_INIT:  state_q <= ST_IDLE;
							ST_CLEAR: state_q <= ST_RES_RD;
							default:  state_q <= ST_FI_END;
						endcase
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_q    <= s_tuser;
						px_q     <= s_tdata[6:0];
						py_q     <= s_tdata[13:7];
						pz_q     <= s_tdata[20:14];
						rad_q    <= in_rad;
						inside_q <= in_inside;
						cx_q     <= '0;
						cy_q     <= '0;
						cz_q     <= '0;
						case (s_tuser)
							REQ_MARK: state_q <= ST_MARK_RD;
							REQ_CLEAR: begin
								occ_cnt_q <= '0;
								ready_q   <= 1'b0;
								state_q   <= ST_CLEAR;
							end
							REQ_COMPUTE: state_q <= ST_FI;
							REQ_FREE: begin
								ox_q      <= in_rneg;
								oy_q      <= in_rneg;
								oz_q      <= in_rneg;
								free_ok_q <= in_inside;
								state_q   <= ST_FREE;
							end
							default: state_q <= ST_RES_RD;
						endcase
					end
				end
				ST_MARK_RD: state_q <= ST_MARK_WR;
				ST_MARK_WR: begin
					if (inside_q && !occ_rd_q) occ_cnt_q <= occ_cnt_q + 1'b1;
					ready_q <= 1'b0;
					state_q <= ST_RES_RD;
				end
				ST_FI_END: begin
					vx_q      <= '0;
					vy_q      <= '0;
					vz_q      <= '0;
					dir_q     <= 1'b0;
					changed_q <= 1'b0;
					ni_q      <= '0;
					nj_q      <= '0;
					nk_q      <= '0;
					best_q    <= DIST_INF;
					state_q   <= ST_RX_RD;
				end
				ST_RX_RD: begin
					if (nk_q != 2'd2) begin
						nk_q <= nk_q + 1'b1;
					end else begin
						nk_q <= '0;
						if (nj_q != 2'd2) begin
							nj_q <= nj_q + 1'b1;
						end else begin
							nj_q <= '0;
							ni_q <= ni_q + 1'b1;
						end
					end
					if ((ni_q == 2'd2) && (nj_q == 2'd2) && (nk_q == 2'd2))
						state_q <= ST_RX_WAIT;
				end
				ST_RX_WAIT: state_q <= ST_RX_WB;
				ST_RX_WB: begin
					if (wr_now) changed_q <= 1'b1;
					best_q  <= DIST_INF;
					ni_q    <= '0;
					state_q <= ST_RX_RD;
					if (!dir_q) begin
						if (ESW'(vz_q) != esz - 1'b1) begin
							vz_q <= vz_q + 1'b1;
						end else begin
							vz_q <= '0;
							if (ESW'(vy_q) != esy - 1'b1) begin
								vy_q <= vy_q + 1'b1;
							end else begin
								vy_q <= '0;
								if (ESW'(vx_q) != esx - 1'b1) begin
									vx_q <= vx_q + 1'b1;
								end else begin
									// Forward sweep done; start the backward one
									dir_q <= 1'b1;
									vx_q  <= DW'(esx - 1'b1);
									vy_q  <= DW'(esy - 1'b1);
									vz_q  <= DW'(esz - 1'b1);
								end
							end
						end
					end else begin
						if (vz_q != '0) begin
							vz_q <= vz_q - 1'b1;
						end else begin
							vz_q <= DW'(esz - 1'b1);
							if (vy_q != '0) begin
								vy_q <= vy_q - 1'b1;
							end else begin
								vy_q <= DW'(esy - 1'b1);
								if (vx_q != '0) begin
									vx_q <= vx_q - 1'b1;
								end else if (changed_q || wr_now) begin
									dir_q     <= 1'b0;
									changed_q <= 1'b0;
									vx_q      <= '0;
									vy_q      <= '0;
									vz_q      <= '0;
								end else begin
									ready_q <= 1'b1;
									state_q <= ST_RES_RD;
								end
							end
						end
					end
				end
				ST_FREE: begin
					if (in_sph && !f_in && ub_q) free_ok_q <= 1'b0;
					if (oz_q != rs) begin
						oz_q <= oz_q + 1'b1;
					end else begin
						oz_q <= 5'sd0 - rs;
						if (oy_q != rs) begin
							oy_q <= oy_q + 1'b1;
						end else begin
							oy_q <= 5'sd0 - rs;
							ox_q <= ox_q + 1'b1;
						end
					end
					if (off_last) state_q <= ST_FREE_END;
				end
				ST_FREE_END: state_q <= ST_RES_RD;
				ST_RES_RD:   state_q <= ST_RES;
				ST_RES: begin
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= {4'b0000, occ_cnt_q, ready_q, inside_q,
						(req_q == REQ_FREE) && free_ok_q, occ_v, dv};
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
